[sv/lbc_pkg.sv]
// Package for the block cache controller: request/result structs, codes, sizes.
// No dependencies; lru_block_cache_controller imports it.
package lbc_pkg;
	localparam int NumSlots = 16;
	localparam int SlotBits = 4;
	localparam int SectorBits = 32;
	localparam int LeaseBits = 8;
	localparam int AgeBits = 4;
	localparam logic [LeaseBits-1:0] LeaseMax = 8'hFF;
	localparam logic [AgeBits-1:0] AgeMax = 4'hF;

	localparam logic [2:0] FuncRead = 3'd0;
	localparam logic [2:0] FuncWrite = 3'd1;
	localparam logic [2:0] FuncReturn = 3'd2;
	localparam logic [2:0] FuncFlush = 3'd3;
	localparam logic [2:0] FuncFlushAll = 3'd4;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StBusy = 2'd1;
	localparam logic [1:0] StUnleased = 2'd2;
	localparam logic [1:0] StSaturated = 2'd3;

	// list work chosen at the decide step
	localparam logic [1:0] PhNone = 2'd0;   // no list change
	localparam logic [1:0] PhGrant = 2'd1;  // take a slot for a miss
	localparam logic [1:0] PhInsert = 2'd2; // returned slot becomes most recent
	localparam logic [1:0] PhPin = 2'd3;    // hit slot leaves the list

	typedef struct packed {
		logic [2:0] func;
		logic [31:0] sector;
		logic [3:0] slot;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot_out;
		logic hit;
		logic fetch_needed;
		logic writeback_valid;
		logic [31:0] writeback_sector;
		logic last;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_REMOVE, S_INSERT, S_FLUSH, S_FLUSH_RD,
		S_OUT, S_WAIT
	} state_t;
endpackage

[sv/lbc_ram.sv]
// Generic single-port RAM, registered read.
// No dependencies.
module lbc_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] addr,
	input logic [Width-1:0] wdata,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// read-first port, read registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[sv/lru_block_cache_controller.sv]
// Sector cache tag/LRU controller with 16 slots. A request is taken, then the
// sequencer walks the slot table one slot per cycle with a single compare unit.
// Every read or write runs a search, a decide step, a list removal pass and an
// insert pass before its result is offered; the next request is taken only
// after that result is. Return and flush slot skip the search. A flush-all
// steps past each clean slot and reads out each dirty slot, emitting one result
// per dirty slot (a single cleared result if none is dirty) and waiting for each
// to be taken. Output stalls hold the controller until the result is taken. Not
// ready while busy. Depends on lbc_pkg and lbc_ram.
module lru_block_cache_controller
	import lbc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input req_t in_data,
	output logic out_valid,
	input logic out_ready,
	output rsp_t out_data
);
	state_t state_q, state_d;
	req_t req_q;
	logic [SlotBits:0] idx_q;
	logic [SlotBits-1:0] tgt_q, hit_slot_q, free_slot_q, best_q;
	logic found_q, free_q, best_ok_q, wb_q;
	logic [1:0] phase_q; // list work for the remove and insert passes
	rsp_t rsp_q;

	logic [NumSlots-1:0] valid_q, dirty_q, listed_q;
	logic [LeaseBits-1:0] lease_q [NumSlots];
	logic [AgeBits-1:0] age_q [NumSlots];

	logic ram_we;
	logic [SlotBits-1:0] ram_addr;
	logic [SectorBits-1:0] ram_rdata;
	logic [SlotBits-1:0] i;
	logic scan_done;

	assign i = idx_q[SlotBits-1:0];
	assign scan_done = idx_q[SlotBits];

	lbc_ram #(.Width(SectorBits), .Depth(NumSlots)) u_tags (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(req_q.sector), .rdata(ram_rdata)
	);

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = rsp_q;

	// tag RAM: read slot i during scan, hold the target slot while its tag is needed, write it on a grant
	always_comb begin
		ram_we = 1'b0;
		ram_addr = i;
		unique case (state_q)
			S_DECIDE: ram_addr = best_q;
			S_REMOVE: ram_addr = tgt_q;
			S_FLUSH_RD: ram_addr = tgt_q;
			S_INSERT: begin
				ram_addr = tgt_q;
				ram_we = (phase_q == PhGrant) && scan_done;
			end
			default: ram_addr = i;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				priority if (in_data.func == FuncRead || in_data.func == FuncWrite)
					state_d = S_SCAN;
				else if (in_data.func == FuncReturn || in_data.func == FuncFlush)
					state_d = S_DECIDE;
				else if (in_data.func == FuncFlushAll) state_d = S_FLUSH;
				else state_d = S_IDLE;
			end
			S_SCAN: if (scan_done) state_d = S_DECIDE;
			S_DECIDE: state_d = S_REMOVE;
			S_REMOVE: if (scan_done) state_d = S_INSERT;
			S_INSERT: if (scan_done) state_d = S_OUT;
			S_FLUSH: if (scan_done) state_d = S_OUT;
				else if (valid_q[i] && dirty_q[i]) state_d = S_FLUSH_RD;
			S_FLUSH_RD: state_d = S_WAIT;
			S_WAIT: state_d = S_OUT;
			S_OUT: if (out_ready) state_d = rsp_q.last ? S_IDLE : S_FLUSH;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// datapath: one slot examined per cycle in the scan and list passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			listed_q <= '0;
			for (int k = 0; k < NumSlots; k++) begin
				lease_q[k] <= '0;
				age_q[k] <= '0;
			end
			idx_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			best_ok_q <= 1'b0;
			wb_q <= 1'b0;
			phase_q <= PhNone;
			req_q <= '0;
			tgt_q <= '0;
			hit_slot_q <= '0;
			free_slot_q <= '0;
			best_q <= '0;
			rsp_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					req_q <= in_data;
					idx_q <= '0;
					found_q <= 1'b0;
					free_q <= 1'b0;
					best_ok_q <= 1'b0;
					wb_q <= 1'b0;
					tgt_q <= in_data.slot;
					rsp_q <= '0;
				end
				S_SCAN: if (!scan_done) begin
					// ram data for slot i-1 arrives this cycle
					if (idx_q != '0 && !found_q && valid_q[i-1'b1]
							&& ram_rdata == req_q.sector) begin
						found_q <= 1'b1;
						hit_slot_q <= i - 1'b1;
					end
					if (!free_q && !valid_q[i]) begin
						free_q <= 1'b1;
						free_slot_q <= i;
					end
					if (listed_q[i] && (!best_ok_q || age_q[i] > age_q[best_q])) begin
						best_ok_q <= 1'b1;
						best_q <= i;
					end
					idx_q <= idx_q + 1'b1;
				end else if (!found_q && valid_q[NumSlots-1]
						&& ram_rdata == req_q.sector) begin
					found_q <= 1'b1;
					hit_slot_q <= SlotBits'(NumSlots - 1);
				end
				S_DECIDE: begin
					idx_q <= '0;
					rsp_q.last <= 1'b1;
					priority if (req_q.func == FuncReturn) begin
						rsp_q.slot_out <= req_q.slot;
						if (lease_q[req_q.slot] == '0) begin
							rsp_q.status <= StUnleased;
							phase_q <= PhNone;
						end else begin
							lease_q[req_q.slot] <= lease_q[req_q.slot] - 1'b1;
							phase_q <= (lease_q[req_q.slot] == LeaseBits'(1)) ? PhInsert : PhNone;
						end
					end else if (req_q.func == FuncFlush) begin
						rsp_q.slot_out <= req_q.slot;
						phase_q <= PhNone;
						if (valid_q[req_q.slot] && dirty_q[req_q.slot]) begin
							dirty_q[req_q.slot] <= 1'b0;
							wb_q <= 1'b1;
						end
					end else if (found_q) begin
						tgt_q <= hit_slot_q;
						rsp_q.slot_out <= hit_slot_q;
						rsp_q.hit <= 1'b1;
						if (lease_q[hit_slot_q] == LeaseMax) begin
							rsp_q.status <= StSaturated;
							phase_q <= PhNone;
						end else begin
							lease_q[hit_slot_q] <= lease_q[hit_slot_q] + 1'b1;
							if (req_q.func == FuncWrite) dirty_q[hit_slot_q] <= 1'b1;
							phase_q <= PhPin;
						end
					end else if (free_q) begin
						tgt_q <= free_slot_q;
						rsp_q.slot_out <= free_slot_q;
						rsp_q.fetch_needed <= 1'b1;
						phase_q <= PhGrant;
					end else if (best_ok_q) begin
						tgt_q <= best_q;
						rsp_q.slot_out <= best_q;
						rsp_q.fetch_needed <= 1'b1;
						rsp_q.writeback_valid <= dirty_q[best_q];
						wb_q <= dirty_q[best_q];
						phase_q <= PhGrant;
					end else begin
						rsp_q.status <= StBusy;
						rsp_q.slot_out <= '0;
						phase_q <= PhNone;
					end
				end
				S_REMOVE: begin
					// take tgt off the list for a hit or a grant, one slot a cycle
					if (!scan_done) begin
						if ((phase_q == PhPin || phase_q == PhGrant) && listed_q[tgt_q]
								&& i != tgt_q && listed_q[i] && age_q[i] > age_q[tgt_q]) begin
							age_q[i] <= age_q[i] - 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end else begin
						if (phase_q == PhPin || phase_q == PhGrant) begin
							listed_q[tgt_q] <= 1'b0;
							age_q[tgt_q] <= '0;
						end
						// victim tag, read while the address held tgt
						if (wb_q && req_q.func != FuncFlush) rsp_q.writeback_sector <= ram_rdata;
						idx_q <= '0;
					end
				end
				S_INSERT: begin
					if (!scan_done) begin
						if (phase_q == PhInsert && listed_q[i] && age_q[i] < AgeMax)
							age_q[i] <= age_q[i] + 1'b1;
						idx_q <= idx_q + 1'b1;
					end else begin
						if (phase_q == PhInsert) begin
							listed_q[tgt_q] <= 1'b1;
							age_q[tgt_q] <= '0;
						end
						if (phase_q == PhGrant) begin
							valid_q[tgt_q] <= 1'b1;
							lease_q[tgt_q] <= 8'd1;
							dirty_q[tgt_q] <= (req_q.func == FuncWrite);
						end
						if (req_q.func == FuncFlush && wb_q) begin
							rsp_q.writeback_valid <= 1'b1;
							rsp_q.writeback_sector <= ram_rdata;
						end
					end
				end
				S_FLUSH: if (!scan_done) begin
					if (valid_q[i] && dirty_q[i]) begin
						tgt_q <= i;
						dirty_q[i] <= 1'b0;
						wb_q <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end else if (!wb_q) begin
					// nothing dirty: the cleared result closes the request
					rsp_q.last <= 1'b1;
				end
				S_FLUSH_RD: idx_q <= idx_q + 1'b1;
				S_WAIT: begin
					rsp_q.slot_out <= tgt_q;
					rsp_q.writeback_valid <= 1'b1;
					rsp_q.writeback_sector <= ram_rdata;
					rsp_q.last <= (idx_q == 5'(NumSlots)) || !(|(valid_q & dirty_q));
				end
				S_OUT: if (out_ready && !rsp_q.last) wb_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// a granted request always lands on a valid slot
	a_grant_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rsp_q.fetch_needed) |-> valid_q[rsp_q.slot_out])
		else $error("granted slot not valid");
	// a pinned slot is never on the list
	a_hit_unlisted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rsp_q.hit && rsp_q.status == StOk) |-> !listed_q[rsp_q.slot_out])
		else $error("hit slot still listed");
	// input is held off while a result waits
	a_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready while output pending");
endmodule
